FILE: rtl/bil_pkg.sv
// Shared types, codes and sizing helpers for the byte insert/remove list.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bil_pkg;

  // Default list depth and fixed field widths
  localparam int BIL_DEPTH   = 64;
  localparam int MODE_W      = 3;
  localparam int POS_W       = 7;
  localparam int DATA_W      = 8;
  localparam int REQ_W       = 16;
  localparam int STAT_W      = 2;
  localparam int CNT_OUT_W   = 7;

  // Read tree fan-in per registered level
  localparam int RD_FANIN    = 8;
  localparam int RD_FANIN_LG = 3;

  typedef enum logic [MODE_W-1:0] {
    MD_INS_AT   = 3'd0,
    MD_APPEND   = 3'd1,
    MD_REM_AT   = 3'd2,
    MD_REM_LAST = 3'd3,
    MD_RD_AT    = 3'd4,
    MD_RD_LAST  = 3'd5,
    MD_CLEAR    = 3'd6,
    MD_SET_SIZE = 3'd7
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Operation broadcast to every cell; all zero when no request is taken
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
    logic rd;
  } bil_cmd_t;

  // Nodes left after lvl levels of the read tree
  function automatic int bil_tree_nodes(int depth, int lvl);
    int n;
    n = depth;
    for (int i = 0; i < lvl; i++) begin
      n = (n + RD_FANIN - 1) >> RD_FANIN_LG;
    end
    return n;
  endfunction

  // Registered levels needed to bring depth leaves down to one
  function automatic int bil_tree_levels(int depth);
    int n;
    int lv;
    n  = depth;
    lv = 0;
    while (n > 1) begin
      n  = (n + RD_FANIN - 1) >> RD_FANIN_LG;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

FILE: rtl/bil_cell.sv
// One list entry: holds a byte and shifts with its neighbors on insert/remove.
// Depends on bil_pkg.
`timescale 1ns / 1ps

module bil_cell #(
  parameter int DEPTH = bil_pkg::BIL_DEPTH,
  parameter int IDX   = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bil_pkg::bil_cmd_t               cmd,
  input  logic [$clog2(DEPTH+1)-1:0]      at,
  input  logic [$clog2(DEPTH+1)-1:0]      count,
  input  logic [$clog2(DEPTH+1)-1:0]      last,
  input  logic [bil_pkg::DATA_W-1:0]      din,
  input  logic [bil_pkg::DATA_W-1:0]      left,
  input  logic [bil_pkg::DATA_W-1:0]      right,
  output logic [bil_pkg::DATA_W-1:0]      value,
  output logic [bil_pkg::DATA_W-1:0]      leaf
);
  import bil_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [DATA_W-1:0] value_next;

  // Pick the next byte from the broadcast operation
  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (MyIdx == at) begin
        value_next = din;
      end else if (MyIdx > at && MyIdx <= count) begin
        value_next = left;
      end
    end else if (cmd.rem) begin
      if (MyIdx >= at && MyIdx < last) begin
        value_next = right;
      end else if (MyIdx == last) begin
        value_next = '0;
      end
    end else if (cmd.clr) begin
      if (MyIdx < count) begin
        value_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

  // Offer the byte to the read tree only when addressed
  assign leaf = (cmd.rd && MyIdx == at) ? value : '0;

endmodule

FILE: rtl/bil_rdtree.sv
// Registered OR tree that collects the one addressed cell byte.
// Depends on bil_pkg (fan-in and level helpers).
`timescale 1ns / 1ps

module bil_rdtree #(
  parameter int DEPTH = bil_pkg::BIL_DEPTH
) (
  input  logic                              clk,
  input  logic [DEPTH*bil_pkg::DATA_W-1:0]  leaves,
  output logic [bil_pkg::DATA_W-1:0]        result
);
  import bil_pkg::*;

  localparam int Levels = bil_tree_levels(DEPTH);

  logic [DEPTH-1:0][DATA_W-1:0] node [1:Levels];

  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int N  = bil_tree_nodes(DEPTH, l);
    localparam int NP = bil_tree_nodes(DEPTH, l - 1);
    logic [DEPTH-1:0][DATA_W-1:0] src;
    logic [DEPTH-1:0][DATA_W-1:0] orv;

    // Take the cell bytes at the first level, the level below elsewhere
    if (l == 1) begin : g_leaf
      assign src = leaves;
    end else begin : g_inner
      assign src = node[l-1];
    end

    // Merge up to eight children of the level below into each of the N nodes
    always_comb begin
      orv = '0;
      for (int c = 0; c < NP; c++) begin
        orv[c >> RD_FANIN_LG] = orv[c >> RD_FANIN_LG] | src[c];
      end
    end

    always_ff @(posedge clk) begin
      node[l] <= orv;
    end
  end

  assign result = node[Levels][0];

endmodule

FILE: rtl/byte_insert_remove_list.sv
// Top level of the byte insert/remove list: request decode, count, cell row,
// read tree and result buffering. Depends on bil_pkg, bil_cell, bil_rdtree.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_ready   mode, position, byte_in, requested_count
//   result    out        out_valid / out_ready byte_out, status, count_now
//
// Every cell shifts in the cycle a request is taken, so the list itself
// changes as the request is taken; the read byte comes back through the registered
// read tree of L = ceil(log8(DEPTH)) levels (2 for DEPTH 64).
// A new request is not taken until the previous one has left the read tree.
// Reset (rst, synchronous) zeroes every entry and empties the list.
// A result not taken parks in a one-deep buffer; in_ready drops while it is full.
`timescale 1ns / 1ps

module byte_insert_remove_list #(
  parameter int DEPTH = bil_pkg::BIL_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bil_pkg::MODE_W-1:0]      mode,
  input  logic [bil_pkg::POS_W-1:0]       position,
  input  logic [bil_pkg::DATA_W-1:0]      byte_in,
  input  logic [bil_pkg::REQ_W-1:0]       requested_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bil_pkg::DATA_W-1:0]      byte_out,
  output logic [bil_pkg::STAT_W-1:0]      status,
  output logic [bil_pkg::CNT_OUT_W-1:0]   count_now
);
  import bil_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int EW     = (CW > POS_W) ? CW : POS_W;
  localparam int RW     = (CW > REQ_W) ? CW : REQ_W;
  localparam int Levels = bil_tree_levels(DEPTH);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0]        count, count_next, last, at;
  logic [EW-1:0]        pos_x, cnt_x, cnt_new_x;
  logic [RW-1:0]        req_x;
  mode_t                op;
  status_t              st_next;
  bil_cmd_t             cmd;
  logic                 accept;
  logic [Levels-1:0]    rd_pipe;
  logic                 done;
  logic [STAT_W-1:0]    res_stat;
  logic [CNT_OUT_W-1:0] res_cnt;
  logic [DATA_W-1:0]    rd_byte;
  logic                 pend_valid;
  logic [DATA_W-1:0]    pend_byte;
  logic [STAT_W-1:0]    pend_stat;
  logic [CNT_OUT_W-1:0] pend_cnt;

  logic [DATA_W-1:0]       cell_val [DEPTH];
  logic [DEPTH*DATA_W-1:0] leaves;

  assign in_ready = ~(|rd_pipe) & ~pend_valid;
  assign accept   = in_valid & in_ready;
  assign done     = rd_pipe[Levels-1];

  // Decode the request against the current count
  always_comb begin
    op         = mode_t'(mode);
    pos_x      = EW'(position);
    cnt_x      = EW'(count);
    req_x      = RW'(requested_count);
    last       = count - CW'(1);
    at         = CW'(pos_x);
    count_next = count;
    st_next    = ST_OK;
    cmd        = '0;
    case (op)
      MD_INS_AT: begin
        if (pos_x > cnt_x) begin
          st_next = ST_RANGE;
        end else if (count == Full) begin
          st_next = ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      MD_APPEND: begin
        at = count;
        if (count == Full) begin
          st_next = ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = count + CW'(1);
        end
      end
      MD_REM_AT: begin
        if (pos_x >= cnt_x) begin
          st_next = ST_RANGE;
        end else begin
          cmd.rem    = 1'b1;
          count_next = last;
        end
      end
      MD_REM_LAST: begin
        at = last;
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          cmd.rem    = 1'b1;
          count_next = last;
        end
      end
      MD_RD_AT: begin
        if (pos_x >= cnt_x) begin
          st_next = ST_RANGE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      MD_RD_LAST: begin
        at = last;
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      MD_CLEAR: begin
        cmd.clr    = 1'b1;
        count_next = '0;
      end
      MD_SET_SIZE: begin
        count_next = (req_x > RW'(DEPTH)) ? Full : CW'(req_x);
      end
      default: begin
        count_next = count;
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
    cnt_new_x = EW'(count_next);
  end

  // Row of cells, each wired to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    bil_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .at    (at),
      .count (count),
      .last  (last),
      .din   (byte_in),
      .left  (left_v),
      .right (right_v),
      .value (cell_val[i]),
      .leaf  (leaves[i*DATA_W +: DATA_W])
    );
  end

  bil_rdtree #(
    .DEPTH (DEPTH)
  ) u_rdtree (
    .clk    (clk),
    .leaves (leaves),
    .result (rd_byte)
  );

  // Count, in-flight tracking and the fields known at acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pipe <= '0;
    end else begin
      rd_pipe[0] <= accept;
      for (int k = 1; k < Levels; k++) begin
        rd_pipe[k] <= rd_pipe[k-1];
      end
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_stat <= st_next;
      res_cnt  <= cnt_new_x[CNT_OUT_W-1:0];
    end
  end

  // Output register with a one-deep park buffer behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (done) begin
        if (out_valid && !out_ready) begin
          pend_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid  <= pend_valid;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (out_valid && !out_ready) begin
        pend_byte <= rd_byte;
        pend_stat <= res_stat;
        pend_cnt  <= res_cnt;
      end else begin
        byte_out  <= rd_byte;
        status    <= res_stat;
        count_now <= res_cnt;
      end
    end else if (out_valid && out_ready && pend_valid) begin
      byte_out  <= pend_byte;
      status    <= pend_stat;
      count_now <= pend_cnt;
    end
  end

endmodule

FILE: rtl/bil_checker.sv
// Port-level checks for byte_insert_remove_list, bound to the top level.
// Depends on bil_pkg and byte_insert_remove_list.
`timescale 1ns / 1ps

module bil_checker #(
  parameter int DEPTH = bil_pkg::BIL_DEPTH
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bil_pkg::DATA_W-1:0]    byte_out,
  input logic [bil_pkg::STAT_W-1:0]    status,
  input logic [bil_pkg::CNT_OUT_W-1:0] count_now
);
  import bil_pkg::*;

  localparam int CW = (CNT_OUT_W > $clog2(DEPTH + 1)) ? CNT_OUT_W : $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthLow = CW'(DEPTH);

  // A refused request never returns a byte
  a_refused_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> byte_out == '0)
    else $error("refused request returned a nonzero byte");

  // A full refusal reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count_now == DepthLow[CNT_OUT_W-1:0])
    else $error("full refusal with count below depth");

  // An empty report comes with no entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count_now == '0)
    else $error("empty report with nonzero count");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status)
      && $stable(count_now))
    else $error("stalled result changed or dropped");

endmodule

bind byte_insert_remove_list bil_checker #(.DEPTH(DEPTH)) u_bil_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .byte_out  (byte_out),
  .status    (status),
  .count_now (count_now)
);
